[src/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 10;
  localparam int COUNT_W   = 11;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_READ      = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } state_e;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
    logic                      empty_res;
  } rsp_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_r;    // take the left neighbor's word
    logic shift_l;    // take the right neighbor's word
    logic load_sel;   // selected cell loads the new word
    logic bus_load;   // selected cell drives its word onto the read bus
    logic bus_shift;  // read bus moves one cell toward the front
  } cell_ctl_t;

endpackage

[src/deq_cell.sv]
module deq_cell #(
  parameter int IW  = 10,
  parameter int IDX = 0
) (
  input  logic                               clk_i,
  input  deq_pkg::cell_ctl_t                 ctl_i,
  input  logic [IW-1:0]                      sel_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] value_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] left_data_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] right_data_i,
  input  logic signed [deq_pkg::VALUE_W-1:0] right_bus_i,
  output logic signed [deq_pkg::VALUE_W-1:0] data_o,
  output logic signed [deq_pkg::VALUE_W-1:0] bus_o
);

  logic signed [deq_pkg::VALUE_W-1:0] data_q, data_d;
  logic signed [deq_pkg::VALUE_W-1:0] bus_q, bus_d;
  logic                               hit;

  assign hit = (sel_i == IW'(IDX));

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_r) begin
      data_d = left_data_i;
    end else if (ctl_i.shift_l) begin
      data_d = right_data_i;
    end else if (ctl_i.load_sel && hit) begin
      data_d = value_i;
    end
  end

  always_comb begin
    bus_d = bus_q;
    if (ctl_i.bus_load) begin
      bus_d = hit ? data_q : '0;
    end else if (ctl_i.bus_shift) begin
      bus_d = right_bus_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    bus_q  <= bus_d;
  end

  assign data_o = data_q;
  assign bus_o  = bus_q;

endmodule

[src/double_ended_queue_with_index_read_unit.sv]
// Bounded deque of signed 32-bit words built as a row of DEPTH cells. Cell 0 always holds
// the front element and cell count-1 the back one: an insert at the front shifts every
// cell one place toward the back, a remove from the front shifts one place toward the
// front, an insert at the back loads the cell at the current count, and a remove at the
// back only lowers the count. Inserts, removes, clear and rejected requests answer from
// the result register, so one such request is taken per cycle while results are taken.
// In a read of position p the addressed cell puts its word on a registered read bus that
// walks one cell per cycle toward cell 0, and no new request is taken meanwhile.
// An insert into a full store reports full and is dropped, a remove from an empty list
// reports empty, and a read at or past the count reports out of range with a zero word.
// The store needs no clearing after reset; the count alone says which cells are live.
module double_ended_queue_with_index_read_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  deq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output deq_pkg::rsp_t out_data_o
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PXW  = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
  localparam int CXW  = (CW > deq_pkg::COUNT_W) ? CW : deq_pkg::COUNT_W;

  // chain wiring
  logic signed [deq_pkg::VALUE_W-1:0] data_w [DEPTH];
  logic signed [deq_pkg::VALUE_W-1:0] bus_w  [DEPTH];
  deq_pkg::cell_ctl_t                 ctl;
  logic [IW-1:0]                      sel;

  // control state
  deq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [IW-1:0]   rd_cnt_q, rd_cnt_d;
  logic            out_valid_q;
  deq_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_load;

  logic            out_free;
  logic            accept;
  logic [PXW-1:0]  pos_x;
  logic            full;
  logic            empty;
  logic            in_range;
  logic            read_start;
  logic            read_done;
  logic [CXW-1:0]  count_x;
  deq_pkg::status_e status;

  // result register can take a new result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != deq_pkg::FSM_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_x      = PXW'(in_data_i.position);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign in_range   = (pos_x < PXW'(count_q));
  assign read_start = accept && (in_data_i.op == deq_pkg::OP_READ) && in_range;
  assign read_done  = (state_q == deq_pkg::FSM_READ) && (rd_cnt_q == '0) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      deq_pkg::FSM_IDLE: begin
        if (read_start) begin
          state_d = deq_pkg::FSM_READ;
        end
      end
      deq_pkg::FSM_READ: begin
        if (read_done) begin
          state_d = deq_pkg::FSM_IDLE;
        end
      end
      default: state_d = deq_pkg::FSM_IDLE;
    endcase
  end

  // chain command, count update and result
  always_comb begin
    ctl      = '0;
    sel      = count_q[IW-1:0];
    count_d  = count_q;
    rd_cnt_d = rd_cnt_q;
    status   = deq_pkg::STAT_OK;
    rsp_load = 1'b0;
    rsp_d    = rsp_q;
    case (state_q)
      deq_pkg::FSM_IDLE: begin
        if (accept) begin
          case (in_data_i.op)
            deq_pkg::OP_INS_FRONT: begin
              if (full) begin
                status = deq_pkg::STAT_FULL;
              end else begin
                ctl.shift_r = 1'b1;
                count_d     = count_q + CW'(1);
              end
            end
            deq_pkg::OP_INS_BACK: begin
              if (full) begin
                status = deq_pkg::STAT_FULL;
              end else begin
                ctl.load_sel = 1'b1;
                count_d      = count_q + CW'(1);
              end
            end
            deq_pkg::OP_REM_FRONT: begin
              if (empty) begin
                status = deq_pkg::STAT_EMPTY;
              end else begin
                ctl.shift_l = 1'b1;
                count_d     = count_q - CW'(1);
              end
            end
            deq_pkg::OP_REM_BACK: begin
              if (empty) begin
                status = deq_pkg::STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            deq_pkg::OP_READ: begin
              if (in_range) begin
                // position is below the count, so it fits the cell index
                sel          = pos_x[IW-1:0];
                ctl.bus_load = 1'b1;
                rd_cnt_d     = pos_x[IW-1:0];
              end else begin
                status = deq_pkg::STAT_RANGE;
              end
            end
            deq_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
          // a successful read answers later, from the bus
          if (!read_start) begin
            rsp_load         = 1'b1;
            rsp_d.status     = status;
            rsp_d.read_value = '0;
          end
        end
      end
      deq_pkg::FSM_READ: begin
        if (rd_cnt_q != '0) begin
          ctl.bus_shift = 1'b1;
          rd_cnt_d      = rd_cnt_q - IW'(1);
        end else if (out_free) begin
          rsp_load         = 1'b1;
          rsp_d.status     = deq_pkg::STAT_OK;
          rsp_d.read_value = bus_w[0];
        end
      end
      default: begin
      end
    endcase
    rsp_d.count     = count_x[deq_pkg::COUNT_W-1:0];
    rsp_d.empty_res = (count_d == '0);
  end

  assign count_x = CXW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q <= rd_cnt_d;
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // row of cells, cell 0 is the front of the list
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::VALUE_W-1:0] left_data;
    logic signed [deq_pkg::VALUE_W-1:0] right_data;
    logic signed [deq_pkg::VALUE_W-1:0] right_bus;

    if (i == 0) begin : g_first
      assign left_data = in_data_i.value;
    end else begin : g_mid_l
      assign left_data = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_bus  = '0;
    end else begin : g_mid_r
      assign right_data = data_w[i+1];
      assign right_bus  = bus_w[i+1];
    end

    deq_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .sel_i        (sel),
      .value_i      (in_data_i.value),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .right_bus_i  (right_bus),
      .data_o       (data_w[i]),
      .bus_o        (bus_w[i])
    );
  end

  // the count never passes the store size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above store size");

  // no request is taken while a read walks the bus
  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deq_pkg::FSM_READ) |-> in_stall_o)
    else $error("request taken during a read");

  // the list does not change while a read is in flight
  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deq_pkg::FSM_READ) |=> $stable(count_q))
    else $error("count changed during a read");

  // only a read reaches the read state, and only when in range
  a_read_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deq_pkg::FSM_IDLE && state_d == deq_pkg::FSM_READ) |->
      (accept && in_data_i.op == deq_pkg::OP_READ && in_range))
    else $error("read state entered without a valid read");

  // a failed request never returns a word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != deq_pkg::STAT_OK) |-> (out_data_o.read_value == '0))
    else $error("nonzero word on a failed request");

endmodule

[tb/double_ended_queue_with_index_read_unit_tb.sv]
module double_ended_queue_with_index_read_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = deq_pkg::DEPTH_DEF;
  // a read at the far end walks the whole row, plus the worst stall and gap bursts
  localparam int STALL_LIMIT = 4 * (DEPTH + 2 + 16);
  localparam int DRAIN_CYCLES = 20;

  // op codes the block leaves unused: no change, status ok
  localparam deq_pkg::op_e OP_SPARE_LO = deq_pkg::op_e'(3'd6);
  localparam deq_pkg::op_e OP_SPARE_HI = deq_pkg::op_e'(3'd7);

  logic clk_i;
  logic rst_ni = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_stall;
  deq_pkg::req_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  deq_pkg::rsp_t  out_data;

  double_ended_queue_with_index_read_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // deque predictor: ring store, front index and element count of our own
  // ---------------------------------------------------------------------------
  logic signed [deq_pkg::VALUE_W-1:0] deque_mem [DEPTH];
  int head_idx = 0;
  int elem_cnt = 0;
  int peak_cnt = 0;

  // applies one request to the predicted deque and returns the response it owes
  function automatic deq_pkg::rsp_t deque_apply(deq_pkg::req_t req);
    deq_pkg::rsp_t rsp;
    rsp = '0;
    rsp.status = deq_pkg::STAT_OK;
    case (req.op)
      deq_pkg::OP_INS_FRONT: begin
        if (elem_cnt >= DEPTH) begin
          rsp.status = deq_pkg::STAT_FULL;
        end else begin
          head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
          deque_mem[head_idx] = req.value;
          elem_cnt++;
        end
      end
      deq_pkg::OP_INS_BACK: begin
        if (elem_cnt >= DEPTH) begin
          rsp.status = deq_pkg::STAT_FULL;
        end else begin
          deque_mem[(head_idx + elem_cnt) % DEPTH] = req.value;
          elem_cnt++;
        end
      end
      deq_pkg::OP_REM_FRONT: begin
        if (elem_cnt == 0) begin
          rsp.status = deq_pkg::STAT_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % DEPTH;
          elem_cnt--;
        end
      end
      deq_pkg::OP_REM_BACK: begin
        if (elem_cnt == 0) begin
          rsp.status = deq_pkg::STAT_EMPTY;
        end else begin
          elem_cnt--;
        end
      end
      deq_pkg::OP_READ: begin
        // also catches every read of an empty list
        if (int'(req.position) >= elem_cnt) begin
          rsp.status = deq_pkg::STAT_RANGE;
        end else begin
          rsp.read_value = deque_mem[(head_idx + int'(req.position)) % DEPTH];
        end
      end
      deq_pkg::OP_CLEAR: begin
        head_idx = 0;
        elem_cnt = 0;
      end
      default: begin
        // spare codes leave the list alone
      end
    endcase
    if (elem_cnt > peak_cnt) peak_cnt = elem_cnt;
    rsp.count     = elem_cnt[deq_pkg::COUNT_W-1:0];
    rsp.empty_res = (elem_cnt == 0);
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  deq_pkg::req_t outgoing_req_q [$];   // requests waiting for the driver
  deq_pkg::rsp_t predicted_rsp_q [$];  // responses owed by the block, oldest first

  int error_count    = 0;
  int requests_seen  = 0;
  int responses_seen = 0;
  int full_seen      = 0;
  int empty_seen     = 0;
  int range_seen     = 0;

  // idle knobs, changed per phase by the stimulus block
  int send_idle_pct = 20;
  int recv_idle_pct = 20;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: next request goes out once the current one is taken
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        // sender idle burst in progress
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (outgoing_req_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= outgoing_req_q.pop_front();
        if ($urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on request handshakes, checks on response handshakes,
  // and drives the response-side stall bursts
  // ---------------------------------------------------------------------------
  int recv_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    deq_pkg::rsp_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      // predict first so a same-edge response still finds its expectation
      if (in_valid && !in_stall) begin
        predicted_rsp_q.push_back(deque_apply(in_data));
        requests_seen++;
      end

      if (out_valid && !out_stall) begin
        responses_seen++;
        case (out_data.status)
          deq_pkg::STAT_FULL:  full_seen++;
          deq_pkg::STAT_EMPTY: empty_seen++;
          deq_pkg::STAT_RANGE: range_seen++;
          default: ;
        endcase
        if (predicted_rsp_q.size() == 0) begin
          report_mismatch("response arrived with no request outstanding");
        end else begin
          want = predicted_rsp_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("response %0d status got %0d want %0d",
                                      responses_seen, out_data.status, want.status));
          if (out_data.read_value !== want.read_value)
            report_mismatch($sformatf("response %0d read_value got %h want %h",
                                      responses_seen, out_data.read_value,
                                      want.read_value));
          if (out_data.count !== want.count)
            report_mismatch($sformatf("response %0d count got %0d want %0d",
                                      responses_seen, out_data.count, want.count));
          if (out_data.empty_res !== want.empty_res)
            report_mismatch($sformatf("response %0d empty_res got %b want %b",
                                      responses_seen, out_data.empty_res,
                                      want.empty_res));
        end
      end

      // response-side stall bursts
      if (recv_gap != 0) begin
        out_stall <= 1'b1;
        recv_gap  <= recv_gap - 1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_stall <= 1'b1;
        recv_gap  <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no handshake on either side ends the run
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d responses owed",
               quiet_cycles, predicted_rsp_q.size());
      $display("[double_ended_queue_with_index_read_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int gen_count = 0;  // element count as seen by the generator

  task automatic queue_req(input deq_pkg::op_e op,
                           input logic [deq_pkg::VALUE_W-1:0] value,
                           input logic [deq_pkg::POS_W-1:0] pos);
    deq_pkg::req_t req;
    req.op       = op;
    req.value    = value;
    req.position = pos;
    outgoing_req_q.push_back(req);
    case (op)
      deq_pkg::OP_INS_FRONT, deq_pkg::OP_INS_BACK: if (gen_count < DEPTH) gen_count++;
      deq_pkg::OP_REM_FRONT, deq_pkg::OP_REM_BACK: if (gen_count > 0) gen_count--;
      deq_pkg::OP_CLEAR:                           gen_count = 0;
      default: ;
    endcase
  endtask

  // read position: mostly a live element, sometimes anything the field holds
  function automatic logic [deq_pkg::POS_W-1:0] pick_position();
    if (gen_count > 0 && $urandom_range(0, 4) != 0)
      return deq_pkg::POS_W'($urandom_range(0, gen_count - 1));
    return deq_pkg::POS_W'($urandom_range(0, (1 << deq_pkg::POS_W) - 1));
  endfunction

  // random mix; whatever is left after inserts, removes and reads is split
  // between clears and spare codes
  task automatic gen_random(input int n, input int ins_pct, input int rem_pct,
                            input int read_pct);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        queue_req($urandom_range(0, 1) ? deq_pkg::OP_INS_BACK : deq_pkg::OP_INS_FRONT,
                  $urandom, deq_pkg::POS_W'($urandom));
      else if (roll < ins_pct + rem_pct)
        queue_req($urandom_range(0, 1) ? deq_pkg::OP_REM_BACK : deq_pkg::OP_REM_FRONT,
                  $urandom, deq_pkg::POS_W'($urandom));
      else if (roll < ins_pct + rem_pct + read_pct)
        queue_req(deq_pkg::OP_READ, $urandom, pick_position());
      else if ($urandom_range(0, 1))
        queue_req(deq_pkg::OP_CLEAR, $urandom, deq_pkg::POS_W'($urandom));
      else
        queue_req($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, $urandom,
                  deq_pkg::POS_W'($urandom));
    end
  endtask

  // sampled on the falling edge, once the driver and monitor have settled
  task automatic wait_all_done();
    while (outgoing_req_q.size() != 0 || in_valid || predicted_rsp_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    int roll;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-list errors, extreme words, reads at both ends and past
    // the end, spare codes, clear, and the front index wrapping below zero
    queue_req(deq_pkg::OP_READ,      32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_REM_FRONT, 32'hffff_ffff, 10'h3ff);
    queue_req(deq_pkg::OP_REM_BACK,  32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_CLEAR,     32'hffff_ffff, 10'h3ff);
    queue_req(deq_pkg::OP_INS_FRONT, 32'h7fff_ffff, 10'd0);
    queue_req(deq_pkg::OP_INS_BACK,  32'h8000_0000, 10'h3ff);
    queue_req(deq_pkg::OP_INS_FRONT, 32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_INS_BACK,  32'hffff_ffff, 10'd0);
    queue_req(deq_pkg::OP_READ,      32'hffff_ffff, 10'd0);
    queue_req(deq_pkg::OP_READ,      32'h0000_0000, 10'd3);
    queue_req(deq_pkg::OP_READ,      32'h0000_0000, 10'd4);
    queue_req(deq_pkg::OP_READ,      32'h0000_0000, 10'h3ff);
    queue_req(OP_SPARE_LO,           32'h1234_5678, 10'd1);
    queue_req(OP_SPARE_HI,           32'hffff_ffff, 10'h3ff);
    queue_req(deq_pkg::OP_REM_FRONT, 32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_REM_BACK,  32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_READ,      32'h0000_0000, 10'd1);
    queue_req(deq_pkg::OP_INS_FRONT, 32'h5555_aaaa, 10'h2aa);
    queue_req(deq_pkg::OP_CLEAR,     32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_READ,      32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_INS_BACK,  32'h1234_5678, 10'h155);
    queue_req(deq_pkg::OP_REM_BACK,  32'h0000_0000, 10'd0);
    queue_req(deq_pkg::OP_REM_FRONT, 32'h0000_0000, 10'd0);

    // short random mix, list stays small
    send_idle_pct = 25;
    recv_idle_pct = 25;
    gen_random(40, 45, 35, 15);

    // sender holds off until every response is back
    wait_all_done();

    // fill the store to the brim with a few reads and removes mixed in
    send_idle_pct = 10;
    recv_idle_pct = 10;
    while (gen_count < DEPTH) begin
      roll = $urandom_range(0, 99);
      if (roll < 1)
        queue_req(deq_pkg::OP_READ, $urandom, pick_position());
      else if (roll < 2)
        queue_req($urandom_range(0, 1) ? deq_pkg::OP_REM_BACK : deq_pkg::OP_REM_FRONT,
                  $urandom, deq_pkg::POS_W'($urandom));
      else
        queue_req($urandom_range(0, 1) ? deq_pkg::OP_INS_BACK : deq_pkg::OP_INS_FRONT,
                  $urandom, deq_pkg::POS_W'($urandom));
    end

    // full store: rejected inserts and a read of the very last element
    queue_req(deq_pkg::OP_INS_FRONT, $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_INS_BACK,  $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_READ,      $urandom, deq_pkg::POS_W'(DEPTH - 1));
    queue_req(deq_pkg::OP_READ,      $urandom, 10'd0);
    queue_req(deq_pkg::OP_REM_BACK,  $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_INS_BACK,  $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_INS_FRONT, $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_REM_FRONT, $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_INS_FRONT, $urandom, deq_pkg::POS_W'($urandom));
    queue_req(deq_pkg::OP_READ,      $urandom, deq_pkg::POS_W'(DEPTH - 1));

    // remove-heavy mix on a long list, then start over from empty
    send_idle_pct = 30;
    recv_idle_pct = 30;
    gen_random(30, 25, 55, 15);
    queue_req(deq_pkg::OP_CLEAR, $urandom, deq_pkg::POS_W'($urandom));

    // last stretch back to back, no idling on either side
    while (outgoing_req_q.size() != 0)
      @(negedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(25, 45, 35, 15);

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (predicted_rsp_q.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", predicted_rsp_q.size()));

    $display("covered %0d requests and %0d responses, list grew to %0d of %0d",
             requests_seen, responses_seen, peak_cnt, DEPTH);
    $display("rejections seen: %0d full, %0d empty, %0d out of range",
             full_seen, empty_seen, range_seen);
    if (error_count == 0) begin
      $display("[double_ended_queue_with_index_read_unit] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[double_ended_queue_with_index_read_unit] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/deq_pkg.sv
src/deq_cell.sv
src/double_ended_queue_with_index_read_unit.sv
tb/double_ended_queue_with_index_read_unit_tb.sv
